// ===== rtl/rbs_pkg.sv =====
// rbs_pkg: shared types, constants and fixed-point helpers of the rgb565 bilinear sampler
// used by every module of the block; depends on nothing
package rbs_pkg;

  localparam int DEF_IMAGE_HEIGHT = 256;
  localparam int DEF_IMAGE_WIDTH  = 256;
  localparam int FRACTION_SCALE   = 1000;

  localparam int COORD_W  = 18;
  localparam int QUOT_W   = 9;
  localparam int FRAC_W   = 10;
  localparam int LOAD_W   = 8;
  localparam int PIX_W    = 16;
  localparam int NOISE_W  = 7;
  localparam int GAIN_W   = 16;
  localparam int RTHR_W   = 6;
  localparam int GTHR_W   = 7;
  localparam int BTHR_W   = 6;
  localparam int WEIGHT_W = 20;
  localparam int SUM_W    = 27;
  localparam int LEVEL_W  = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_THR   = 2'd3;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // x / 1000 as (x * 268436) >> 28, exact for x below 2^18
  localparam int RECIP_SCALE_W     = 19;
  localparam logic [RECIP_SCALE_W-1:0] RECIP_SCALE = 19'd268436;
  localparam int RECIP_SCALE_SHIFT = 28;
  localparam int SCALE_PROD_W      = COORD_W + RECIP_SCALE_W;

  // x / 1000000 as ((x >> 6) * 2199024) >> 35, exact for x below 2^27
  localparam int DIV_PRE_SHIFT   = 6;
  localparam int RECIP_DIV_W     = 22;
  localparam logic [RECIP_DIV_W-1:0] RECIP_DIV = 22'd2199024;
  localparam int RECIP_DIV_SHIFT = 35;
  localparam int MIL_PROD_W      = SUM_W - DIV_PRE_SHIFT + RECIP_DIV_W;

  localparam logic [PIX_W-1:0] PIX_OUTSIDE = 16'h00FF;
  localparam logic [PIX_W-1:0] PIX_BLACK   = 16'h0000;

  localparam logic [PIX_W-1:0] CHAN_MASK [3] = '{16'hF800, 16'h07E0, 16'h001F};
  localparam int CHAN_SHIFT [3] = '{11, 5, 0};
  localparam logic [LEVEL_W-1:0] CHAN_MAX [3] = '{7'd31, 7'd63, 7'd31};

  // the block's own pipeline depth from an accepted sample to its strobe
  localparam int PIPE_LAT = 9;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [3:0][PIX_W-1:0] quad_t;

  typedef struct packed {
    logic               action;
    logic [LOAD_W-1:0]  load_row;
    logic [LOAD_W-1:0]  load_col;
    pix_t               load_pixel;
    logic [COORD_W-1:0] sample_row;
    logic [COORD_W-1:0] sample_col;
    logic [NOISE_W-1:0] noise_red;
    logic [NOISE_W-1:0] noise_green;
    logic [NOISE_W-1:0] noise_blue;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [LOAD_W-1:0] w_row;
    logic [LOAD_W-1:0] w_col;
    pix_t              w_data;
    logic              re;
    logic [QUOT_W-1:0] r_row;
    logic [QUOT_W-1:0] r_col;
  } store_req_t;

  typedef struct packed {
    logic               oor;
    logic [FRAC_W-1:0]  a;
    logic [FRAC_W-1:0]  b;
    logic [NOISE_W-1:0] noise_red;
    logic [NOISE_W-1:0] noise_green;
    logic [NOISE_W-1:0] noise_blue;
  } meta_t;

  typedef struct packed {
    logic [GAIN_W-1:0] noise_gain;
    logic [RTHR_W-1:0] red_thr;
    logic [GTHR_W-1:0] green_thr;
    logic [BTHR_W-1:0] blue_thr;
  } cfg_t;

  function automatic logic [QUOT_W-1:0] div_by_scale(input logic [COORD_W-1:0] x);
    logic [SCALE_PROD_W-1:0] prod;
    prod = SCALE_PROD_W'(x) * SCALE_PROD_W'(RECIP_SCALE);
    return prod[RECIP_SCALE_SHIFT +: QUOT_W];
  endfunction

  function automatic logic [LEVEL_W-1:0] div_by_million(input logic [SUM_W-1:0] x);
    logic [MIL_PROD_W-1:0] prod;
    prod = MIL_PROD_W'(x[SUM_W-1:DIV_PRE_SHIFT]) * MIL_PROD_W'(RECIP_DIV);
    return prod[RECIP_DIV_SHIFT +: LEVEL_W];
  endfunction

  function automatic logic [5:0] chan_level(input pix_t p, input int c);
    pix_t t;
    t = (p & CHAN_MASK[c]) >> CHAN_SHIFT[c];
    return t[5:0];
  endfunction

endpackage

// ===== rtl/rbs_coord.sv =====
// rbs_coord: input stage, coordinate split into whole and fractional parts, store requests
// depends on rbs_pkg
module rbs_coord #(
  parameter int IMAGE_HEIGHT = rbs_pkg::DEF_IMAGE_HEIGHT,
  parameter int IMAGE_WIDTH  = rbs_pkg::DEF_IMAGE_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rbs_pkg::item_t      in_item,
  output rbs_pkg::store_req_t req,
  output logic                meta_valid,
  output rbs_pkg::meta_t      meta
);

  logic                            s1_valid;
  rbs_pkg::item_t                  s1_item;
  logic                            s2_valid;
  rbs_pkg::item_t                  s2_item;
  logic [rbs_pkg::QUOT_W-1:0]      s2_qrow;
  logic [rbs_pkg::QUOT_W-1:0]      s2_qcol;
  logic [rbs_pkg::COORD_W-1:0]     rem_row;
  logic [rbs_pkg::COORD_W-1:0]     rem_col;
  logic                            oor;
  logic                            load_in_image;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_item <= in_item;
    end
    s2_item <= s1_item;
    s2_qrow <= rbs_pkg::div_by_scale(s1_item.sample_row);
    s2_qcol <= rbs_pkg::div_by_scale(s1_item.sample_col);
  end

  always_comb begin
    rem_row = s2_item.sample_row -
              rbs_pkg::COORD_W'(s2_qrow) * rbs_pkg::COORD_W'(rbs_pkg::FRACTION_SCALE);
    rem_col = s2_item.sample_col -
              rbs_pkg::COORD_W'(s2_qcol) * rbs_pkg::COORD_W'(rbs_pkg::FRACTION_SCALE);
    oor = (32'(s2_qrow) + 32'd1 >= 32'(IMAGE_HEIGHT)) ||
          (32'(s2_qcol) + 32'd1 >= 32'(IMAGE_WIDTH));
    load_in_image = (32'(s2_item.load_row) < 32'(IMAGE_HEIGHT)) &&
                    (32'(s2_item.load_col) < 32'(IMAGE_WIDTH));

    // loads and samples meet the store in the same stage, so order is kept
    req.we     = s2_valid && (s2_item.action == rbs_pkg::ACT_LOAD) && load_in_image;
    req.w_row  = s2_item.load_row;
    req.w_col  = s2_item.load_col;
    req.w_data = s2_item.load_pixel;
    req.re     = s2_valid && (s2_item.action == rbs_pkg::ACT_SAMPLE) && !oor;
    req.r_row  = s2_qrow;
    req.r_col  = s2_qcol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= 1'b0;
    end else begin
      meta_valid <= s2_valid && (s2_item.action == rbs_pkg::ACT_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    meta.oor         <= oor;
    meta.a           <= rem_row[rbs_pkg::FRAC_W-1:0];
    meta.b           <= rem_col[rbs_pkg::FRAC_W-1:0];
    meta.noise_red   <= s2_item.noise_red;
    meta.noise_green <= s2_item.noise_green;
    meta.noise_blue  <= s2_item.noise_blue;
  end

endmodule

// ===== rtl/rbs_bank.sv =====
// rbs_bank: one bank of the image store, one write and one registered read port
// depends on rbs_pkg
module rbs_bank #(
  parameter int DEPTH  = 1,
  parameter int ADDR_W = 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  rbs_pkg::pix_t       wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output rbs_pkg::pix_t       rdata
);

  rbs_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rbs_store.sv =====
// rbs_store: image store split into four banks by row and column parity
// so the four neighbors come out in one read; depends on rbs_pkg and rbs_bank
module rbs_store #(
  parameter int IMAGE_HEIGHT = rbs_pkg::DEF_IMAGE_HEIGHT,
  parameter int IMAGE_WIDTH  = rbs_pkg::DEF_IMAGE_WIDTH
) (
  input  logic                clk,
  input  rbs_pkg::store_req_t req,
  output rbs_pkg::quad_t      px
);

  // rows and columns past the load coordinate range are never written
  localparam int LOAD_SPAN  = 1 << rbs_pkg::LOAD_W;
  localparam int EFF_H      = (IMAGE_HEIGHT < LOAD_SPAN) ? IMAGE_HEIGHT : LOAD_SPAN;
  localparam int EFF_W      = (IMAGE_WIDTH < LOAD_SPAN) ? IMAGE_WIDTH : LOAD_SPAN;
  localparam int BANK_ROWS  = (EFF_H + 1) / 2;
  localparam int BANK_COLS  = (EFF_W + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [rbs_pkg::QUOT_W:0] rrow [2];
  logic [rbs_pkg::QUOT_W:0] rcol [2];
  logic [ADDR_W-1:0]        raddr [4];
  logic [ADDR_W-1:0]        waddr;
  logic [1:0]               wbank;
  rbs_pkg::quad_t           rdata;
  logic                     rd_row0;
  logic                     rd_col0;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      // the row (column) of parity k among the two neighbors
      rrow[k] = {1'b0, req.r_row} + (rbs_pkg::QUOT_W + 1)'(req.r_row[0] != 1'(k));
      rcol[k] = {1'b0, req.r_col} + (rbs_pkg::QUOT_W + 1)'(req.r_col[0] != 1'(k));
    end
    for (int bk = 0; bk < 4; bk++) begin
      raddr[bk] = ADDR_W'(32'(rrow[bk / 2] >> 1) * BANK_COLS + 32'(rcol[bk % 2] >> 1));
    end
    wbank = {req.w_row[0], req.w_col[0]};
    waddr = ADDR_W'(32'(req.w_row >> 1) * BANK_COLS + 32'(req.w_col >> 1));
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rbs_bank #(
      .DEPTH (BANK_DEPTH),
      .ADDR_W(ADDR_W)
    ) u_bank (
      .clk  (clk),
      .we   (req.we && (wbank == 2'(g))),
      .waddr(waddr),
      .wdata(req.w_data),
      .re   (req.re),
      .raddr(raddr[g]),
      .rdata(rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_row0 <= req.r_row[0];
      rd_col0 <= req.r_col[0];
    end
  end

  // order: row/col, row+1/col, row/col+1, row+1/col+1
  always_comb begin
    px[0] = rdata[{rd_row0, rd_col0}];
    px[1] = rdata[{~rd_row0, rd_col0}];
    px[2] = rdata[{rd_row0, ~rd_col0}];
    px[3] = rdata[{~rd_row0, ~rd_col0}];
  end

endmodule

// ===== rtl/rbs_blend.sv =====
// rbs_blend: weights, per-channel weighted sums, noise, scaling, saturation and keying
// depends on rbs_pkg
module rbs_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            meta_valid,
  input  rbs_pkg::meta_t  meta,
  input  rbs_pkg::quad_t  px,
  input  rbs_pkg::cfg_t   cfg,
  output logic            result_valid,
  output rbs_pkg::pix_t   sampled_pixel,
  output logic            out_of_range
);

  typedef struct packed {
    logic          oor;
    logic          any_zero;
    rbs_pkg::pix_t max;
  } side_t;

  logic [rbs_pkg::FRAC_W-1:0]   na;
  logic [rbs_pkg::FRAC_W-1:0]   nb;
  rbs_pkg::pix_t                max_lo;
  rbs_pkg::pix_t                max_hi;

  logic                         s4_valid;
  side_t                        s4_side;
  rbs_pkg::quad_t               s4_px;
  logic [rbs_pkg::WEIGHT_W-1:0] s4_w [4];
  logic [rbs_pkg::NOISE_W-1:0]  s4_noise [3];

  logic                         s5_valid;
  side_t                        s5_side;
  logic [rbs_pkg::SUM_W-1:0]    s5_prod [3][4];
  logic [rbs_pkg::SUM_W-1:0]    s5_noise [3];

  logic                         s6_valid;
  side_t                        s6_side;
  logic [rbs_pkg::SUM_W-1:0]    s6_sum [3];
  logic [rbs_pkg::SUM_W-1:0]    s6_noise [3];
  logic                         s6_nonzero;

  logic                         s7_valid;
  side_t                        s7_side;
  logic [rbs_pkg::SUM_W-1:0]    s7_sum [3];

  logic                         s8_valid;
  side_t                        s8_side;
  logic [rbs_pkg::LEVEL_W-1:0]  s8_q [3];

  logic [rbs_pkg::LEVEL_W-1:0]  lvl [3];
  logic                         keyed;
  rbs_pkg::pix_t                blend_pix;

  always_comb begin
    na     = rbs_pkg::FRAC_W'(rbs_pkg::FRACTION_SCALE) - meta.a;
    nb     = rbs_pkg::FRAC_W'(rbs_pkg::FRACTION_SCALE) - meta.b;
    max_lo = (px[0] >= px[1]) ? px[0] : px[1];
    max_hi = (px[2] >= px[3]) ? px[2] : px[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      s6_valid     <= 1'b0;
      s7_valid     <= 1'b0;
      s8_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s4_valid     <= meta_valid;
      s5_valid     <= s4_valid;
      s6_valid     <= s5_valid;
      s7_valid     <= s6_valid;
      s8_valid     <= s7_valid;
      result_valid <= s8_valid;
    end
  end

  // weights and the zero-neighbor shortcut
  always_ff @(posedge clk) begin
    s4_side.oor      <= meta.oor;
    s4_side.any_zero <= (px[0] == rbs_pkg::PIX_BLACK) || (px[1] == rbs_pkg::PIX_BLACK) ||
                        (px[2] == rbs_pkg::PIX_BLACK) || (px[3] == rbs_pkg::PIX_BLACK);
    s4_side.max      <= (max_lo >= max_hi) ? max_lo : max_hi;
    s4_px            <= px;
    s4_w[0]          <= rbs_pkg::WEIGHT_W'(na) * rbs_pkg::WEIGHT_W'(nb);
    s4_w[1]          <= rbs_pkg::WEIGHT_W'(meta.a) * rbs_pkg::WEIGHT_W'(nb);
    s4_w[2]          <= rbs_pkg::WEIGHT_W'(na) * rbs_pkg::WEIGHT_W'(meta.b);
    s4_w[3]          <= rbs_pkg::WEIGHT_W'(meta.a) * rbs_pkg::WEIGHT_W'(meta.b);
    s4_noise[0]      <= meta.noise_red;
    s4_noise[1]      <= meta.noise_green;
    s4_noise[2]      <= meta.noise_blue;
  end

  always_ff @(posedge clk) begin
    s5_side <= s4_side;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        s5_prod[c][k] <= rbs_pkg::SUM_W'(s4_w[k]) *
                         rbs_pkg::SUM_W'(rbs_pkg::chan_level(s4_px[k], c));
      end
      s5_noise[c] <= rbs_pkg::SUM_W'(cfg.noise_gain) * rbs_pkg::SUM_W'(s4_noise[c]);
    end
  end

  always_ff @(posedge clk) begin
    s6_side <= s5_side;
    for (int c = 0; c < 3; c++) begin
      s6_sum[c]   <= s5_prod[c][0] + s5_prod[c][1] + s5_prod[c][2] + s5_prod[c][3];
      s6_noise[c] <= s5_noise[c];
    end
  end

  assign s6_nonzero = (s6_sum[0] != '0) && (s6_sum[1] != '0) && (s6_sum[2] != '0);

  // noise only lands when every channel sum is nonzero
  always_ff @(posedge clk) begin
    s7_side <= s6_side;
    for (int c = 0; c < 3; c++) begin
      s7_sum[c] <= s6_sum[c] + (s6_nonzero ? s6_noise[c] : '0);
    end
  end

  always_ff @(posedge clk) begin
    s8_side <= s7_side;
    for (int c = 0; c < 3; c++) begin
      s8_q[c] <= rbs_pkg::div_by_million(s7_sum[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lvl[c] = (s8_q[c] > rbs_pkg::CHAN_MAX[c]) ? rbs_pkg::CHAN_MAX[c] : s8_q[c];
    end
    keyed = (lvl[0] < rbs_pkg::LEVEL_W'(cfg.red_thr)) &&
            (lvl[1] < rbs_pkg::LEVEL_W'(cfg.green_thr)) &&
            (lvl[2] < rbs_pkg::LEVEL_W'(cfg.blue_thr));
    blend_pix = keyed ? rbs_pkg::PIX_BLACK : {lvl[0][4:0], lvl[1][5:0], lvl[2][4:0]};
  end

  always_ff @(posedge clk) begin
    out_of_range <= s8_side.oor;
    if (s8_side.oor) begin
      sampled_pixel <= rbs_pkg::PIX_OUTSIDE;
    end else if (s8_side.any_zero) begin
      sampled_pixel <= s8_side.max;
    end else begin
      sampled_pixel <= blend_pix;
    end
  end

endmodule

// ===== rtl/rgb565_bilinear_sampler.sv =====
// rgb565_bilinear_sampler: top level, configuration registers and pipeline wiring
// depends on rbs_pkg, rbs_coord, rbs_store, rbs_blend
//
// channel   signals                                        transfer when
// command   start, busy, action .. noise_blue              start && !busy
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid && cfg_ready
// result    result_valid, sampled_pixel, out_of_range      result_valid (one cycle)
//
// one item per cycle; a sample's result strobes once its command transfer has passed the coordinate
// split (two stages), the banked store read and the blend pipeline.
// loads give no result and reach the store in the same stage as sample reads.
// busy and !cfg_ready only during reset; the store needs no clearing pass.
// results cannot be held off, so nothing in the pipeline ever stalls.
module rgb565_bilinear_sampler #(
  parameter int IMAGE_HEIGHT = rbs_pkg::DEF_IMAGE_HEIGHT,
  parameter int IMAGE_WIDTH  = rbs_pkg::DEF_IMAGE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic [rbs_pkg::LOAD_W-1:0]        load_row,
  input  logic [rbs_pkg::LOAD_W-1:0]        load_col,
  input  logic [rbs_pkg::PIX_W-1:0]         load_pixel,
  input  logic [rbs_pkg::COORD_W-1:0]       sample_row,
  input  logic [rbs_pkg::COORD_W-1:0]       sample_col,
  input  logic [rbs_pkg::NOISE_W-1:0]       noise_red,
  input  logic [rbs_pkg::NOISE_W-1:0]       noise_green,
  input  logic [rbs_pkg::NOISE_W-1:0]       noise_blue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              result_valid,
  output logic [rbs_pkg::PIX_W-1:0]         sampled_pixel,
  output logic                              out_of_range
);

  rbs_pkg::cfg_t       cfg;
  rbs_pkg::item_t      in_item;
  rbs_pkg::store_req_t store_req;
  rbs_pkg::meta_t      meta;
  rbs_pkg::quad_t      px;
  logic                meta_valid;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbs_pkg::REG_NOISE_GAIN: cfg.noise_gain <= cfg_data[rbs_pkg::GAIN_W-1:0];
        rbs_pkg::REG_RED_THR:    cfg.red_thr    <= cfg_data[rbs_pkg::RTHR_W-1:0];
        rbs_pkg::REG_GREEN_THR:  cfg.green_thr  <= cfg_data[rbs_pkg::GTHR_W-1:0];
        rbs_pkg::REG_BLUE_THR:   cfg.blue_thr   <= cfg_data[rbs_pkg::BTHR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.action      = action;
    in_item.load_row    = load_row;
    in_item.load_col    = load_col;
    in_item.load_pixel  = load_pixel;
    in_item.sample_row  = sample_row;
    in_item.sample_col  = sample_col;
    in_item.noise_red   = noise_red;
    in_item.noise_green = noise_green;
    in_item.noise_blue  = noise_blue;
  end

  rbs_coord #(
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_coord (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_item   (in_item),
    .req       (store_req),
    .meta_valid(meta_valid),
    .meta      (meta)
  );

  rbs_store #(
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_store (
    .clk(clk),
    .req(store_req),
    .px (px)
  );

  rbs_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .meta_valid   (meta_valid),
    .meta         (meta),
    .px           (px),
    .cfg          (cfg),
    .result_valid (result_valid),
    .sampled_pixel(sampled_pixel),
    .out_of_range (out_of_range)
  );

`ifndef NO_ASSERTIONS
  a_sample_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == rbs_pkg::ACT_SAMPLE) |-> ##(rbs_pkg::PIPE_LAT) result_valid)
    else $error("sample transfer without a result");

  a_result_from_sample: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && action == rbs_pkg::ACT_SAMPLE, rbs_pkg::PIPE_LAT))
    else $error("result without a sample transfer");

  a_store_one_access: assert property (@(posedge clk) disable iff (rst)
    !(store_req.we && store_req.re))
    else $error("store write and read in the same cycle");

  a_outside_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_of_range) |-> (sampled_pixel == rbs_pkg::PIX_OUTSIDE))
    else $error("out of range result with wrong pixel");
`endif

endmodule
